// ===== design/rau_pkg.sv =====
package rau_pkg;

  // operand field width, fixed by the word layout
  localparam int OPERAND_WIDTH = 16;
  // magnitude width that holds every product and the sum of two products
  localparam int MAG_W = 2 * OPERAND_WIDTH;
  localparam int RES_NUM_W = 33;
  localparam int RES_DEN_W = 31;
  localparam int ACT_W = 3;

  localparam logic [ACT_W-1:0] ACT_ADD = 3'd0;
  localparam logic [ACT_W-1:0] ACT_SUB = 3'd1;
  localparam logic [ACT_W-1:0] ACT_MUL = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DIV = 3'd3;
  localparam logic [ACT_W-1:0] ACT_RED = 3'd4;

  typedef struct packed {
    logic [ACT_W-1:0]                action;
    logic signed [OPERAND_WIDTH-1:0] a_num;
    logic signed [OPERAND_WIDTH-1:0] a_den;
    logic signed [OPERAND_WIDTH-1:0] b_num;
    logic signed [OPERAND_WIDTH-1:0] b_den;
  } in_word_t;

  typedef struct packed {
    logic signed [RES_NUM_W-1:0] res_num;
    logic [RES_DEN_W-1:0]        res_den;
    logic                        status;
  } out_word_t;

endpackage

// ===== design/rau_div.sv =====
module rau_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rau_pkg::MAG_W-1:0] dividend_i,
  input  logic [rau_pkg::MAG_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [rau_pkg::MAG_W-1:0] quot_o
);
  import rau_pkg::*;

  localparam int CW = $clog2(MAG_W + 1);

  logic [MAG_W-1:0] quot_q, rem_q, dsr_q;
  logic [MAG_W-1:0] quot_d, rem_d;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic [MAG_W:0]   shifted, diff;
  logic             ge;

  // one restoring step per cycle
  always_comb begin
    shifted = {rem_q, quot_q[MAG_W-1]};
    diff    = shifted - {1'b0, dsr_q};
    ge      = shifted >= {1'b0, dsr_q};
    rem_d   = ge ? diff[MAG_W-1:0] : shifted[MAG_W-1:0];
    quot_d  = {quot_q[MAG_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(MAG_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dsr_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== design/rau_gcd.sv =====
module rau_gcd (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rau_pkg::MAG_W-1:0] a_i,
  input  logic [rau_pkg::MAG_W-1:0] b_i,
  output logic                      done_o,
  output logic [rau_pkg::MAG_W-1:0] gcd_o
);
  import rau_pkg::*;

  localparam int KW = $clog2(MAG_W);

  logic [MAG_W-1:0] u_q, v_q, g_q;
  logic [KW-1:0]    k_q;
  logic             busy_q, done_q;
  logic             u_zero;

  // b_i is never zero, so v stays nonzero and u reaches zero
  assign u_zero = (u_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && u_zero) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // binary gcd: one shift or one compare and subtract per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      u_q <= a_i;
      v_q <= b_i;
      k_q <= '0;
    end else if (busy_q) begin
      if (u_zero) begin
        g_q <= v_q << k_q;
      end else if (!u_q[0] && !v_q[0]) begin
        u_q <= u_q >> 1;
        v_q <= v_q >> 1;
        k_q <= k_q + 1'b1;
      end else if (!u_q[0]) begin
        u_q <= u_q >> 1;
      end else if (!v_q[0]) begin
        v_q <= v_q >> 1;
      end else if (u_q >= v_q) begin
        u_q <= u_q - v_q;
      end else begin
        v_q <= v_q - u_q;
      end
    end
  end

  assign done_o = done_q;
  assign gcd_o  = g_q;

endmodule

// ===== design/rational_arithmetic_unit.sv =====
// Exact fraction arithmetic: each input word carries an action (add, subtract, multiply,
// divide, reduce; unused codes reduce) and two fractions a_num/a_den and b_num/b_den; each
// result word gives the result in lowest terms with a positive denominator, zero as 0/1,
// or status 1 with zero fields when an operand denominator or the result denominator is
// zero. One word is worked at a time and in_stall_o stays high until its result is queued
// in the output register. An error on an operand denominator goes from the check step
// straight to output, and a division by a zero fraction is caught at the combine step; any
// other word goes through accept, check, up to three products on the one shared multiplier,
// combine, a binary gcd taking one shift or subtract per cycle (its step count set by the
// operand bits), then two divisions on one shift-subtract divider, and output.
// A finished result waits in the output register while the next word is taken.
module rational_arithmetic_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rau_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rau_pkg::out_word_t  out_word_o
);
  import rau_pkg::*;

  localparam int W     = OPERAND_WIDTH;
  localparam int EXT_W = (MAG_W + 1 > RES_NUM_W) ? MAG_W + 1 : RES_NUM_W;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1;
  localparam logic [3:0] S_MUL_A = 4'd2;
  localparam logic [3:0] S_MUL_B = 4'd3;
  localparam logic [3:0] S_MUL_C = 4'd4;
  localparam logic [3:0] S_COMB  = 4'd5;
  localparam logic [3:0] S_GCD   = 4'd6;
  localparam logic [3:0] S_DIVN  = 4'd7;
  localparam logic [3:0] S_DIVD  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  // sign and magnitude
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } sm_t;

  function automatic logic [W-1:0] abs_val(input logic [W-1:0] v);
    abs_val = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic sm_t sm_add(input sm_t x, input sm_t y);
    sm_t r;
    if (x.neg == y.neg) begin
      r.mag = x.mag + y.mag;
      r.neg = x.neg;
    end else if (x.mag >= y.mag) begin
      r.mag = x.mag - y.mag;
      r.neg = x.neg;
    end else begin
      r.mag = y.mag - x.mag;
      r.neg = y.neg;
    end
    sm_add = r;
  endfunction

  logic [3:0]       state_q, state_d;
  logic             out_valid_q, out_valid_d;
  out_word_t        out_q, out_res;

  // captured operands
  logic [ACT_W-1:0] act_q;
  logic             an_neg_q, ad_neg_q, bn_neg_q, bd_neg_q;
  logic [W-1:0]     an_mag_q, ad_mag_q, bn_mag_q, bd_mag_q;

  // products, raw numerator and denominator, error flag
  sm_t              m1_q, m2_q, m3_q;
  sm_t              num_q, den_q;
  sm_t              comb_num, comb_den;
  logic             err_q;

  logic             accept, uses_b, op_err, load_out;
  logic [W-1:0]     mul_x, mul_y;
  logic             mul_neg;
  logic [MAG_W-1:0] mul_p;

  logic             gcd_start, gcd_done;
  logic [MAG_W-1:0] gcd_g;
  logic             div_start, div_done;
  logic [MAG_W-1:0] div_dividend, div_quot;

  logic             res_neg;
  logic [EXT_W-1:0] ext_mag, ext_val;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign uses_b     = (act_q <= ACT_DIV);
  assign op_err     = (ad_mag_q == '0) || (uses_b && (bd_mag_q == '0));
  // a result moves into the output register once the previous one is gone
  assign load_out   = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  // shared multiplier, operands picked by the step
  always_comb begin
    case (state_q)
      S_MUL_A: begin
        mul_x   = an_mag_q;
        mul_y   = (act_q == ACT_MUL) ? bn_mag_q : bd_mag_q;
        mul_neg = an_neg_q ^ ((act_q == ACT_MUL) ? bn_neg_q : bd_neg_q);
      end
      S_MUL_B: begin
        mul_x   = ad_mag_q;
        mul_y   = bn_mag_q;
        mul_neg = ad_neg_q ^ bn_neg_q;
      end
      default: begin
        mul_x   = ad_mag_q;
        mul_y   = bd_mag_q;
        mul_neg = ad_neg_q ^ bd_neg_q;
      end
    endcase
    mul_p = MAG_W'(mul_x) * MAG_W'(mul_y);
  end

  // raw numerator and denominator from the stored products
  always_comb begin
    case (act_q)
      ACT_ADD: begin
        comb_num = sm_add(m1_q, m2_q);
        comb_den = m3_q;
      end
      ACT_SUB: begin
        comb_num = sm_add(m1_q, sm_t'{neg: !m2_q.neg, mag: m2_q.mag});
        comb_den = m3_q;
      end
      ACT_MUL: begin
        comb_num = m1_q;
        comb_den = m3_q;
      end
      ACT_DIV: begin
        comb_num = m1_q;
        comb_den = m2_q;
      end
      default: begin
        comb_num = '{neg: an_neg_q, mag: MAG_W'(an_mag_q)};
        comb_den = '{neg: ad_neg_q, mag: MAG_W'(ad_mag_q)};
      end
    endcase
  end

  assign gcd_start    = (state_q == S_COMB) && (comb_den.mag != '0);
  assign div_start    = ((state_q == S_GCD) && gcd_done) || ((state_q == S_DIVN) && div_done);
  assign div_dividend = (state_q == S_GCD) ? num_q.mag : den_q.mag;

  rau_gcd u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .a_i     (comb_num.mag),
    .b_i     (comb_den.mag),
    .done_o  (gcd_done),
    .gcd_o   (gcd_g)
  );

  rau_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (gcd_g),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_CHK;
      end
      S_CHK: begin
        if (op_err) state_d = S_OUT;
        else if (!uses_b) state_d = S_COMB;
        else state_d = S_MUL_A;
      end
      S_MUL_A: state_d = S_MUL_B;
      S_MUL_B: state_d = S_MUL_C;
      S_MUL_C: state_d = S_COMB;
      S_COMB: begin
        state_d = (comb_den.mag == '0) ? S_OUT : S_GCD;
      end
      S_GCD: begin
        if (gcd_done) state_d = S_DIVN;
      end
      S_DIVN: begin
        if (div_done) state_d = S_DIVD;
      end
      S_DIVD: begin
        if (div_done) state_d = S_OUT;
      end
      S_OUT: begin
        if (load_out) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q    <= in_word_i.action;
      an_neg_q <= in_word_i.a_num[W-1];
      ad_neg_q <= in_word_i.a_den[W-1];
      bn_neg_q <= in_word_i.b_num[W-1];
      bd_neg_q <= in_word_i.b_den[W-1];
      an_mag_q <= abs_val(in_word_i.a_num);
      ad_mag_q <= abs_val(in_word_i.a_den);
      bn_mag_q <= abs_val(in_word_i.b_num);
      bd_mag_q <= abs_val(in_word_i.b_den);
      err_q    <= 1'b0;
    end
    case (state_q)
      S_CHK: begin
        if (op_err) err_q <= 1'b1;
      end
      S_MUL_A: m1_q <= '{neg: mul_neg, mag: mul_p};
      S_MUL_B: m2_q <= '{neg: mul_neg, mag: mul_p};
      S_MUL_C: m3_q <= '{neg: mul_neg, mag: mul_p};
      S_COMB: begin
        num_q <= comb_num;
        den_q <= comb_den;
        if (comb_den.mag == '0) err_q <= 1'b1;
      end
      S_DIVN: begin
        if (div_done) num_q.mag <= div_quot;
      end
      S_DIVD: begin
        if (div_done) den_q.mag <= div_quot;
      end
      default: begin
      end
    endcase
    if (load_out) out_q <= out_res;
  end

  // result word: sign goes on the numerator, zero numerator stays positive
  always_comb begin
    res_neg = (num_q.mag != '0) && (num_q.neg != den_q.neg);
    ext_mag = EXT_W'(num_q.mag);
    ext_val = res_neg ? (~ext_mag + 1'b1) : ext_mag;
    if (err_q) begin
      out_res.res_num = '0;
      out_res.res_den = '0;
      out_res.status  = 1'b1;
    end else begin
      out_res.res_num = ext_val[RES_NUM_W-1:0];
      out_res.res_den = RES_DEN_W'(den_q.mag);
      out_res.status  = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // error words carry zero fields
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.status) |->
      (out_word_o.res_num == '0 && out_word_o.res_den == '0))
    else $error("error word with nonzero fields");

  // gcd finishes only while the sequencer waits for it
  a_gcd_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gcd_done |-> (state_q == S_GCD))
    else $error("gcd done outside its step");

  // divider finishes only in a division step
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIVN || state_q == S_DIVD))
    else $error("divider done outside a division step");

  // an accepted word always starts with the operand check
  a_accept_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_CHK))
    else $error("accepted word skipped the check step");

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  import rau_pkg::*;

  localparam int ITEM_COUNT = 850;
  localparam int MAX_WAIT = 13;
  // covers the slowest word, plus a full gap and a full stall on top
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 250;

  // codes outside the documented set, all of them behave as reduce
  localparam logic [ACT_W-1:0] ACT_SPARE5 = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE7 = 3'd7;

  localparam logic ST_OK = 1'b0;
  localparam logic ST_ZERO_DEN = 1'b1;

  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t want;
  } directed_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  out_word_t expected_fractions[$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  int        stall_left = 0;
  bit        sink_calm = 1'b0;
  bit        source_calm = 1'b0;

  rational_arithmetic_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // exact fraction result: signed 64-bit holds every product and sum
  function automatic out_word_t predict_fraction(in_word_t w);
    longint an, ad, bn, bd, num, den, x, y, t;
    out_word_t r;
    an = longint'($signed(w.a_num));
    ad = longint'($signed(w.a_den));
    bn = longint'($signed(w.b_num));
    bd = longint'($signed(w.b_den));
    r = '0;
    r.status = ST_ZERO_DEN;
    // b only matters for the four two-operand actions
    if (ad == 0 || (w.action <= ACT_DIV && bd == 0)) return r;
    case (w.action)
      ACT_ADD: begin
        num = an * bd + ad * bn;
        den = ad * bd;
      end
      ACT_SUB: begin
        num = an * bd - ad * bn;
        den = ad * bd;
      end
      ACT_MUL: begin
        num = an * bn;
        den = ad * bd;
      end
      ACT_DIV: begin
        num = an * bd;
        den = ad * bn;
      end
      default: begin
        num = an;
        den = ad;
      end
    endcase
    // dividing by a zero fraction
    if (den == 0) return r;
    x = (num < 0) ? -num : num;
    y = (den < 0) ? -den : den;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    num = num / x;
    den = den / x;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    r.res_num = num[RES_NUM_W-1:0];
    r.res_den = den[RES_DEN_W-1:0];
    r.status = ST_OK;
    return r;
  endfunction

  function automatic directed_t row(logic [ACT_W-1:0] act, int an, int ad, int bn, int bd,
                                    bit typed = 1'b0, longint num = 0, longint den = 0,
                                    logic st = ST_OK);
    directed_t r;
    r.word.action = act;
    r.word.a_num = an[OPERAND_WIDTH-1:0];
    r.word.a_den = ad[OPERAND_WIDTH-1:0];
    r.word.b_num = bn[OPERAND_WIDTH-1:0];
    r.word.b_den = bd[OPERAND_WIDTH-1:0];
    r.typed = typed;
    r.want.res_num = num[RES_NUM_W-1:0];
    r.want.res_den = den[RES_DEN_W-1:0];
    r.want.status = st;
    return r;
  endfunction

  // mix of extremes, small values that share factors, and full-range values
  function automatic logic [OPERAND_WIDTH-1:0] rand_operand();
    int small_val;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'hffff;
          3: return 16'h0001;
          4: return 16'h8001;
          default: return 16'h0000;
        endcase
      end
      1, 2, 3: begin
        small_val = int'($urandom_range(0, 40)) - 20;
        return small_val[OPERAND_WIDTH-1:0];
      end
      default: return OPERAND_WIDTH'($urandom);
    endcase
  endfunction

  // sender wait per word, with calm stretches where it never idles
  function automatic int draw_wait(bit calm);
    return calm ? 0 : int'($urandom_range(0, MAX_WAIT));
  endfunction

  // present one word, hold it until it is taken, then queue its expected result
  task automatic send_word(in_word_t w, out_word_t want, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk_i); while (in_stall);
    expected_fractions.push_back(want);
  endtask

  // result side: check each accepted word, then stall for a drawn number of cycles
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (expected_fractions.size() == 0) begin
          $display("%0t unexpected word: res_num %0d res_den %0d status %0b", $time,
                   $signed(out_word.res_num), out_word.res_den, out_word.status);
          mismatches++;
        end else begin
          want = expected_fractions.pop_front();
          if (want.res_num !== out_word.res_num) begin
            $display("%0t res_num: expected %0d, actual %0d", $time,
                     $signed(want.res_num), $signed(out_word.res_num));
            mismatches++;
          end
          if (want.res_den !== out_word.res_den) begin
            $display("%0t res_den: expected %0d, actual %0d", $time,
                     want.res_den, out_word.res_den);
            mismatches++;
          end
          if (want.status !== out_word.status) begin
            $display("%0t status: expected %0b, actual %0b", $time,
                     want.status, out_word.status);
            mismatches++;
          end
        end
        if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
        stall_left = sink_calm ? 0 : int'($urandom_range(0, MAX_WAIT));
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles where neither side moves a word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t watchdog: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("tb_top NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    directed_t directed_rows[$];
    in_word_t  w;
    out_word_t want;

    // zero, sign handling, extremes, error codes, spare actions
    directed_rows.push_back(row(ACT_RED, 0, 1, 0, 0, 1, 0, 1, ST_OK));
    directed_rows.push_back(row(ACT_RED, 5, 0, 1, 1, 1, 0, 0, ST_ZERO_DEN));
    directed_rows.push_back(row(ACT_ADD, 1, 0, 1, 1, 1, 0, 0, ST_ZERO_DEN));
    directed_rows.push_back(row(ACT_SUB, 1, 1, 1, 0, 1, 0, 0, ST_ZERO_DEN));
    directed_rows.push_back(row(ACT_MUL, 0, 0, 0, 0, 1, 0, 0, ST_ZERO_DEN));
    directed_rows.push_back(row(ACT_RED, 7, 3, 9, 0, 1, 7, 3, ST_OK));
    directed_rows.push_back(row(ACT_DIV, 1, 2, 0, 5, 1, 0, 0, ST_ZERO_DEN));
    directed_rows.push_back(row(ACT_DIV, 0, 3, 0, -5, 1, 0, 0, ST_ZERO_DEN));
    directed_rows.push_back(row(ACT_ADD, 1, 2, 1, 3, 1, 5, 6, ST_OK));
    directed_rows.push_back(row(ACT_SUB, 1, 2, 1, 2, 1, 0, 1, ST_OK));
    directed_rows.push_back(row(ACT_SUB, 0, 7, 0, -3, 1, 0, 1, ST_OK));
    directed_rows.push_back(row(ACT_MUL, -32768, 1, -32768, 1, 1, 1073741824, 1, ST_OK));
    directed_rows.push_back(row(ACT_MUL, -32768, 32767, -32768, 32767));
    directed_rows.push_back(row(ACT_ADD, -32768, 32767, -32768, 32765));
    directed_rows.push_back(row(ACT_SUB, 32767, -32768, -32768, 32767));
    directed_rows.push_back(row(ACT_DIV, 1, -2, -3, 4));
    directed_rows.push_back(row(ACT_DIV, -1, -1, -1, -1, 1, 1, 1, ST_OK));
    directed_rows.push_back(row(ACT_RED, 3, -6, 0, 0, 1, -1, 2, ST_OK));
    directed_rows.push_back(row(ACT_RED, -32768, -32768, 0, 0, 1, 1, 1, ST_OK));
    directed_rows.push_back(row(ACT_RED, 32767, -32768, 0, 0, 1, -32767, 32768, ST_OK));
    directed_rows.push_back(row(ACT_RED, -32768, 32767, 5, 5, 1, -32768, 32767, ST_OK));
    directed_rows.push_back(row(ACT_SPARE5, 4, 8, 1, 0, 1, 1, 2, ST_OK));
    directed_rows.push_back(row(ACT_SPARE6, -4, -8, -1, 0, 1, 1, 2, ST_OK));
    directed_rows.push_back(row(ACT_SPARE7, 0, -5, 0, 0, 1, 0, 1, ST_OK));
    directed_rows.push_back(row(ACT_SPARE7, 1, 0, 3, 4, 1, 0, 0, ST_ZERO_DEN));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      want = directed_rows[i].typed ? directed_rows[i].want
                                    : predict_fraction(directed_rows[i].word);
      if ($urandom_range(0, 39) == 0) source_calm = !source_calm;
      send_word(directed_rows[i].word, want, draw_wait(source_calm));
    end

    for (int n = 0; n < ITEM_COUNT; n++) begin
      // mostly documented actions, now and then a spare code
      if ($urandom_range(0, 9) == 0) w.action = ACT_W'($urandom_range(ACT_SPARE5, ACT_SPARE7));
      else w.action = ACT_W'($urandom_range(ACT_ADD, ACT_RED));
      w.a_num = rand_operand();
      w.a_den = ($urandom_range(0, 19) == 0) ? '0 : rand_operand();
      w.b_num = rand_operand();
      w.b_den = ($urandom_range(0, 19) == 0) ? '0 : rand_operand();
      if ($urandom_range(0, 39) == 0) source_calm = !source_calm;
      send_word(w, predict_fraction(w), draw_wait(source_calm));
    end
    in_valid <= 1'b0;

    while (expected_fractions.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && expected_fractions.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
